// ===== rtl/gcdt_pkg.sv =====
// gcdt_pkg: shared widths, constants and the arctangent table for the
// great-circle distance and travel time pipeline. No dependencies.
package gcdt_pkg;

  localparam int TRIG_ITER = 24;  // CORDIC steps, 12..40
  localparam int LAT_W     = 28;
  localparam int LON_W     = 29;
  localparam int RAD_W     = 24;
  localparam int SPD_W     = 24;
  localparam int DIST_W    = 26;
  localparam int TIME_W    = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  localparam int MAG_W     = 30;  // magnitude of a coordinate difference
  localparam int CW        = 35;  // CORDIC datapath width, signed
  localparam int SQ_W      = 64;  // root datapath width
  localparam int ROOT_W    = 31;
  localparam int QUO_W     = DIST_W + 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd1;

  localparam logic [RAD_W-1:0] RAD_RESET = 24'd1013453;
  localparam logic [SPD_W-1:0] SPD_RESET = 24'd128000;

  localparam longint Q30_ONE  = 64'd1073741824;
  localparam longint HALF_TURN = 64'd2147483648;
  localparam longint CORDIC_K = 64'd652032874;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // floor(2^36/45): quotient low by at most one for 30-bit magnitudes
  localparam logic [30:0] RECIP45 = 31'd1527099483;
  // ceil(2^20/45): exact for the small remainder scaling
  localparam logic [14:0] FRAC45  = 15'd23302;

  typedef logic signed [31:0] q30_t;

  function automatic logic [31:0] arc(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'd536870912;   1: v = 32'd316933406;   2: v = 32'd167458907;
      3: v = 32'd85004756;    4: v = 32'd42667331;    5: v = 32'd21354465;
      6: v = 32'd10679838;    7: v = 32'd5340245;     8: v = 32'd2670163;
      9: v = 32'd1335087;    10: v = 32'd667544;     11: v = 32'd333772;
      12: v = 32'd166886;    13: v = 32'd83443;      14: v = 32'd41722;
      15: v = 32'd20861;     16: v = 32'd10430;      17: v = 32'd5215;
      18: v = 32'd2608;      19: v = 32'd1304;       20: v = 32'd652;
      21: v = 32'd326;       22: v = 32'd163;        23: v = 32'd81;
      24: v = 32'd41;        25: v = 32'd20;         26: v = 32'd10;
      27: v = 32'd5;         28: v = 32'd3;          29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/gcdt_in_if.sv =====
// gcdt_in_if: input channel carrying two coordinate points.
// Depends on gcdt_pkg.
interface gcdt_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [gcdt_pkg::LAT_W-1:0]  start_latitude;
  logic signed [gcdt_pkg::LON_W-1:0]  start_longitude;
  logic signed [gcdt_pkg::LAT_W-1:0]  end_latitude;
  logic signed [gcdt_pkg::LON_W-1:0]  end_longitude;

  modport source (output valid, start_latitude, start_longitude, end_latitude,
                  end_longitude, input ready);
  modport sink   (input valid, start_latitude, start_longitude, end_latitude,
                  end_longitude, output ready);
endinterface

// ===== rtl/gcdt_out_if.sv =====
// gcdt_out_if: result channel with distance, travel time and error flag.
// Depends on gcdt_pkg.
interface gcdt_out_if;
  logic                          valid;
  logic                          ready;
  logic [gcdt_pkg::DIST_W-1:0]   distance;
  logic [gcdt_pkg::TIME_W-1:0]   travel_time;
  logic                          speed_zero_error;

  modport source (output valid, distance, travel_time, speed_zero_error,
                  input ready);
  modport sink   (input valid, distance, travel_time, speed_zero_error,
                  output ready);
endinterface

// ===== rtl/gcdt_phase.sv =====
// gcdt_phase: degrees to turn phase, trunc(mag*256/45) or trunc(mag*512/45),
// sign applied, 3 stages. Depends on gcdt_pkg.
module gcdt_phase (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [gcdt_pkg::MAG_W-1:0]  mag_i,
  input  logic                        neg_i,
  input  logic                        full_i,
  output logic                        vld_o,
  output logic [31:0]                 phase_o
);

  logic [60:0]                 prod_r;
  logic [gcdt_pkg::MAG_W-1:0]  mag_r;
  logic                        neg_a_r, full_a_r, vld_a_r;
  logic [24:0]                 q_r, q_nxt;
  logic [5:0]                  rem_r, rem_nxt;
  logic                        neg_b_r, full_b_r, vld_b_r;
  logic [31:0]                 phase_r, phase_nxt;
  logic                        vld_c_r;

  logic [24:0] q0;
  logic [30:0] r0;
  logic [14:0] sh;
  logic [29:0] fprod;
  logic [8:0]  frac;
  logic [33:0] pmag;

  // quotient estimate is low by at most one
  always_comb begin
    q0 = prod_r[60:36];
    r0 = 31'(mag_r) - 31'(q0 * 25'd45);
    if (r0 >= 31'd45) begin
      q_nxt   = q0 + 25'd1;
      rem_nxt = 6'(r0 - 31'd45);
    end else begin
      q_nxt   = q0;
      rem_nxt = 6'(r0);
    end
  end

  always_comb begin
    sh    = full_b_r ? {rem_r, 9'd0} : {1'b0, rem_r, 8'd0};
    fprod = 30'(sh * gcdt_pkg::FRAC45);
    frac  = fprod[28:20];
    pmag  = full_b_r ? ({q_r, 9'd0} + 34'(frac)) : (34'({q_r, 8'd0}) + 34'(frac));
    phase_nxt = neg_b_r ? 32'(-pmag) : pmag[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_i;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= 61'(mag_i * gcdt_pkg::RECIP45);
      mag_r    <= mag_i;
      neg_a_r  <= neg_i;
      full_a_r <= full_i;
      q_r      <= q_nxt;
      rem_r    <= rem_nxt;
      neg_b_r  <= neg_a_r;
      full_b_r <= full_a_r;
      phase_r  <= phase_nxt;
    end
  end

  assign vld_o   = vld_c_r;
  assign phase_o = phase_r;

endmodule

// ===== rtl/gcdt_rot.sv =====
// gcdt_rot: pipelined rotation CORDIC giving sine and cosine of a phase,
// one stage per step plus entry and exit stages. Depends on gcdt_pkg.
module gcdt_rot (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [31:0]        phase_i,
  output logic               vld_o,
  output gcdt_pkg::q30_t     sin_o,
  output gcdt_pkg::q30_t     cos_o
);

  localparam int N = gcdt_pkg::TRIG_ITER;
  localparam int W = gcdt_pkg::CW;
  localparam logic signed [W-1:0] ONE  = W'(gcdt_pkg::Q30_ONE);
  localparam logic signed [W-1:0] HALF = W'(gcdt_pkg::HALF_TURN);

  logic signed [W-1:0] x_r [0:N];
  logic signed [W-1:0] y_r [0:N];
  logic signed [W-1:0] a_r [0:N];
  logic signed [W-1:0] x_nxt [0:N];
  logic signed [W-1:0] y_nxt [0:N];
  logic signed [W-1:0] a_nxt [0:N];
  logic                neg_r [0:N];
  logic                neg_nxt [0:N];
  logic                vld_r [0:N];
  logic                vld_out_r;
  gcdt_pkg::q30_t      sin_r, cos_r, sin_nxt, cos_nxt;

  logic signed [W-1:0] a0, xf, yf;

  always_comb begin
    a0 = W'($signed(phase_i));
    x_nxt[0] = W'(gcdt_pkg::CORDIC_K);
    y_nxt[0] = '0;
    // fold into the right half plane
    if (a0 > ONE) begin
      a_nxt[0]   = a0 - HALF;
      neg_nxt[0] = 1'b1;
    end else if (a0 < -ONE) begin
      a_nxt[0]   = a0 + HALF;
      neg_nxt[0] = 1'b1;
    end else begin
      a_nxt[0]   = a0;
      neg_nxt[0] = 1'b0;
    end
    for (int i = 0; i < N; i++) begin
      neg_nxt[i+1] = neg_r[i];
      if (a_r[i] >= 0) begin
        x_nxt[i+1] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] + (x_r[i] >>> i);
        a_nxt[i+1] = a_r[i] - W'(gcdt_pkg::arc(i));
      end else begin
        x_nxt[i+1] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] - (x_r[i] >>> i);
        a_nxt[i+1] = a_r[i] + W'(gcdt_pkg::arc(i));
      end
    end
  end

  always_comb begin
    xf = neg_r[N] ? -x_r[N] : x_r[N];
    yf = neg_r[N] ? -y_r[N] : y_r[N];
    if (xf > ONE)       cos_nxt = 32'(ONE);
    else if (xf < -ONE) cos_nxt = 32'(-ONE);
    else                cos_nxt = 32'(xf);
    if (yf > ONE)       sin_nxt = 32'(ONE);
    else if (yf < -ONE) sin_nxt = 32'(-ONE);
    else                sin_nxt = 32'(yf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) vld_r[i] <= 1'b0;
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int i = 0; i < N; i++) vld_r[i+1] <= vld_r[i];
      vld_out_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      a_r   <= a_nxt;
      neg_r <= neg_nxt;
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign vld_o = vld_out_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== rtl/gcdt_isqrt.sv =====
// gcdt_isqrt: pipelined digit-by-digit integer square root, one result bit
// per stage after the entry stage, 33 stages. Depends on gcdt_pkg.
module gcdt_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [gcdt_pkg::SQ_W-1:0]     v_i,
  output logic                          vld_o,
  output logic [gcdt_pkg::ROOT_W-1:0]   root_o
);

  localparam int N = 32;
  localparam int W = gcdt_pkg::SQ_W;

  logic [W-1:0] v_r   [0:N];
  logic [W-1:0] res_r [0:N];
  logic [W-1:0] v_nxt [0:N];
  logic [W-1:0] res_nxt [0:N];
  logic         vld_r [0:N];

  always_comb begin
    logic [W-1:0] bitv;
    v_nxt[0]   = v_i;
    res_nxt[0] = '0;
    for (int i = 0; i < N; i++) begin
      bitv = W'(1) << (62 - 2 * i);
      if (v_r[i] >= res_r[i] + bitv) begin
        v_nxt[i+1]   = v_r[i] - (res_r[i] + bitv);
        res_nxt[i+1] = (res_r[i] >> 1) + bitv;
      end else begin
        v_nxt[i+1]   = v_r[i];
        res_nxt[i+1] = res_r[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int i = 0; i < N; i++) vld_r[i+1] <= vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
    end
  end

  assign vld_o  = vld_r[N];
  assign root_o = res_r[N][gcdt_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/gcdt_vec.sv =====
// gcdt_vec: pipelined vectoring CORDIC, phase of (x, y) clamped to a quarter
// turn. Depends on gcdt_pkg.
module gcdt_vec (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [gcdt_pkg::ROOT_W-1:0]   x_i,
  input  logic [gcdt_pkg::ROOT_W-1:0]   y_i,
  output logic                          vld_o,
  output logic [30:0]                   z_o
);

  localparam int N = gcdt_pkg::TRIG_ITER;
  localparam int W = gcdt_pkg::CW;
  localparam logic signed [W-1:0] ONE = W'(gcdt_pkg::Q30_ONE);

  logic signed [W-1:0] x_r [0:N];
  logic signed [W-1:0] y_r [0:N];
  logic signed [W-1:0] z_r [0:N];
  logic signed [W-1:0] x_nxt [0:N];
  logic signed [W-1:0] y_nxt [0:N];
  logic signed [W-1:0] z_nxt [0:N];
  logic                vld_r [0:N];
  logic                vld_out_r;
  logic [30:0]         z_out_r, z_out_nxt;

  always_comb begin
    x_nxt[0] = W'(x_i);
    y_nxt[0] = W'(y_i);
    z_nxt[0] = '0;
    for (int i = 0; i < N; i++) begin
      if (y_r[i] > 0) begin
        x_nxt[i+1] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] + W'(gcdt_pkg::arc(i));
      end else if (y_r[i] < 0) begin
        x_nxt[i+1] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] - W'(gcdt_pkg::arc(i));
      end else begin
        // zero y holds the vector and phase
        x_nxt[i+1] = x_r[i];
        y_nxt[i+1] = y_r[i];
        z_nxt[i+1] = z_r[i];
      end
    end
    if (z_r[N] < 0)        z_out_nxt = '0;
    else if (z_r[N] > ONE) z_out_nxt = 31'(ONE);
    else                   z_out_nxt = 31'(z_r[N]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) vld_r[i] <= 1'b0;
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int i = 0; i < N; i++) vld_r[i+1] <= vld_r[i];
      vld_out_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      z_out_r <= z_out_nxt;
    end
  end

  assign vld_o = vld_out_r;
  assign z_o   = z_out_r;

endmodule

// ===== rtl/gcdt_div.sv =====
// gcdt_div: pipelined restoring divider, (d << 16) / divisor, one quotient
// bit per stage after the entry stage, 43 stages. Depends on gcdt_pkg.
module gcdt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [gcdt_pkg::DIST_W-1:0]   d_i,
  input  logic [gcdt_pkg::SPD_W-1:0]    div_i,
  output logic                          vld_o,
  output logic [gcdt_pkg::DIST_W-1:0]   d_o,
  output logic [gcdt_pkg::QUO_W-1:0]    q_o
);

  localparam int N  = gcdt_pkg::QUO_W;
  localparam int SW = gcdt_pkg::SPD_W;

  logic [N-1:0]                 n_r   [0:N];
  logic [N-1:0]                 q_r   [0:N];
  logic [SW-1:0]                rem_r [0:N];
  logic [N-1:0]                 n_nxt [0:N];
  logic [N-1:0]                 q_nxt [0:N];
  logic [SW-1:0]                rem_nxt [0:N];
  logic                         vld_r [0:N];

  always_comb begin
    logic [SW:0] rsh;
    n_nxt[0]   = {d_i, 16'd0};
    q_nxt[0]   = '0;
    rem_nxt[0] = '0;
    for (int i = 0; i < N; i++) begin
      n_nxt[i+1] = n_r[i];
      rsh = {rem_r[i], n_r[i][N-1-i]};
      if (rsh >= {1'b0, div_i}) begin
        rem_nxt[i+1] = SW'(rsh - {1'b0, div_i});
        q_nxt[i+1]   = {q_r[i][N-2:0], 1'b1};
      end else begin
        rem_nxt[i+1] = rsh[SW-1:0];
        q_nxt[i+1]   = {q_r[i][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int i = 0; i < N; i++) vld_r[i+1] <= vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign vld_o = vld_r[N];
  assign d_o   = n_r[N][N-1:16];
  assign q_o   = q_r[N];

endmodule

// ===== rtl/great_circle_distance_time_unit.sv =====
// great_circle_distance_time_unit: haversine distance and travel time top.
// Depends on gcdt_pkg, gcdt_in_if, gcdt_out_if, gcdt_phase, gcdt_rot,
// gcdt_isqrt, gcdt_vec and gcdt_div.
//
//  channel | direction | transfer when      | payload
//  in_chan | sink      | valid && ready     | start/end latitude, longitude
//  out_chan| source    | valid && ready     | distance, travel_time, error
//  cfg_*   | write     | cfg_we high        | radius (0), speed (1)
//
// One transfer in per cycle unless a result waits untaken; the depth is set by
// the two CORDIC chains, the 32-step root and the 42-step divider, one step
// per stage.
// Synchronous active-low reset clears valid bits and loads register defaults.
// When the output register holds a result that is not taken, the whole
// pipeline freezes; nothing moves, is dropped or repeats.
module great_circle_distance_time_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  gcdt_in_if.sink                           in_chan,
  gcdt_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [gcdt_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [gcdt_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  localparam int MW = gcdt_pkg::MAG_W;

  // config registers
  logic [gcdt_pkg::RAD_W-1:0] radius_r;
  logic [gcdt_pkg::SPD_W-1:0] speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= gcdt_pkg::RAD_RESET;
      speed_r  <= gcdt_pkg::SPD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        gcdt_pkg::CFG_RADIUS: radius_r <= cfg_wdata[gcdt_pkg::RAD_W-1:0];
        gcdt_pkg::CFG_SPEED:  speed_r  <= cfg_wdata[gcdt_pkg::SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: frozen only while a result waits
  logic en;
  logic out_vld_r;
  assign en            = !out_vld_r || out_chan.ready;
  assign in_chan.ready = en;

  // stage 0: differences, latitudes and their magnitudes
  logic          s0_vld_r;
  logic [MW-1:0] mag_r [0:3];
  logic          neg_r [0:3];
  logic [MW-1:0] mag_nxt [0:3];
  logic          neg_nxt [0:3];

  always_comb begin
    logic signed [MW-1:0] v [0:3];
    v[0] = MW'(in_chan.end_latitude) - MW'(in_chan.start_latitude);
    v[1] = MW'(in_chan.end_longitude) - MW'(in_chan.start_longitude);
    v[2] = MW'(in_chan.start_latitude);
    v[3] = MW'(in_chan.end_latitude);
    for (int k = 0; k < 4; k++) begin
      neg_nxt[k] = v[k][MW-1];
      mag_nxt[k] = v[k][MW-1] ? MW'(-v[k]) : MW'(v[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (en) s0_vld_r <= in_chan.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
    end
  end

  // phases: half differences and full latitudes
  logic [31:0] ph [0:3];
  logic        ph_vld [0:3];

  for (genvar k = 0; k < 4; k++) begin : g_ph
    gcdt_phase u_phase (
      .clk(clk), .rst_n(rst_n), .en(en), .vld_i(s0_vld_r),
      .mag_i(mag_r[k]), .neg_i(neg_r[k]), .full_i(k >= 2),
      .vld_o(ph_vld[k]), .phase_o(ph[k])
    );
  end

  // sine of half differences, cosine of latitudes
  gcdt_pkg::q30_t s1, s2, c1, c2;
  logic           rot_vld;

  gcdt_rot u_rot_dlat (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(ph_vld[0]), .phase_i(ph[0]),
    .vld_o(rot_vld), .sin_o(s1), .cos_o()
  );
  gcdt_rot u_rot_dlon (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(ph_vld[1]), .phase_i(ph[1]),
    .vld_o(), .sin_o(s2), .cos_o()
  );
  gcdt_rot u_rot_lat1 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(ph_vld[2]), .phase_i(ph[2]),
    .vld_o(), .sin_o(), .cos_o(c1)
  );
  gcdt_rot u_rot_lat2 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(ph_vld[3]), .phase_i(ph[3]),
    .vld_o(), .sin_o(), .cos_o(c2)
  );

  // haversine term h in three stages
  gcdt_pkg::q30_t sq1_r, sq2_r, cc_r, sq1_d_r, m_r;
  logic [30:0]    h_r, h_nxt;
  logic           p1_vld_r, p2_vld_r, p3_vld_r;
  logic signed [63:0] pa, pb, pc, pd;
  logic signed [32:0] hs;

  always_comb begin
    pa = 64'(s1 * s1);
    pb = 64'(s2 * s2);
    pc = 64'(c1 * c2);
    pd = 64'(sq2_r * cc_r);
    hs = 33'(sq1_d_r) + 33'(m_r);
    if (hs < 0)                          h_nxt = '0;
    else if (hs > 33'(gcdt_pkg::Q30_ONE)) h_nxt = 31'(gcdt_pkg::Q30_ONE);
    else                                 h_nxt = 31'(hs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= rot_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r   <= 32'(pa >>> 30);
      sq2_r   <= 32'(pb >>> 30);
      cc_r    <= 32'(pc >>> 30);
      sq1_d_r <= sq1_r;
      m_r     <= 32'(pd >>> 30);
      h_r     <= h_nxt;
    end
  end

  // roots of 1-h and h, then the phase of the pair
  logic [gcdt_pkg::ROOT_W-1:0] rx, ry;
  logic                        sq_vld;
  logic [gcdt_pkg::SQ_W-1:0]   va, vb;

  assign va = gcdt_pkg::SQ_W'(31'(gcdt_pkg::Q30_ONE) - h_r) << 30;
  assign vb = gcdt_pkg::SQ_W'(h_r) << 30;

  gcdt_isqrt u_sqrt_x (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(p3_vld_r), .v_i(va),
    .vld_o(sq_vld), .root_o(rx)
  );
  gcdt_isqrt u_sqrt_y (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(p3_vld_r), .v_i(vb),
    .vld_o(), .root_o(ry)
  );

  logic [30:0] z;
  logic        z_vld;

  gcdt_vec u_vec (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(sq_vld), .x_i(rx), .y_i(ry),
    .vld_o(z_vld), .z_o(z)
  );

  // distance = radius * z * pi, rounded, in three stages
  logic [54:0] t_r;
  logic [56:0] thp_r;
  logic [61:0] tlp_r;
  logic [gcdt_pkg::DIST_W-1:0] d_r, d_nxt;
  logic        m1_vld_r, m2_vld_r, m3_vld_r;
  logic [57:0] dsum;

  always_comb begin
    dsum = 58'(thp_r) + 58'(tlp_r >> 30) + (58'(1) << 29);
    if (dsum[57:30] > 28'(gcdt_pkg::DIST_MAX)) d_nxt = gcdt_pkg::DIST_MAX;
    else                                        d_nxt = dsum[55:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= z_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r   <= 55'(radius_r * z);
      thp_r <= 57'(t_r[54:30] * gcdt_pkg::PI_Q30);
      tlp_r <= 62'(t_r[29:0] * gcdt_pkg::PI_Q30);
      d_r   <= d_nxt;
    end
  end

  // travel time
  logic [gcdt_pkg::DIST_W-1:0] dq;
  logic [gcdt_pkg::QUO_W-1:0]  q;
  logic                        div_vld;

  gcdt_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(m3_vld_r), .d_i(d_r),
    .div_i(speed_r), .vld_o(div_vld), .d_o(dq), .q_o(q)
  );

  // output register
  logic [gcdt_pkg::DIST_W-1:0] out_dist_r;
  logic [gcdt_pkg::TIME_W-1:0] out_time_r, time_nxt;
  logic                        out_err_r, err_nxt;

  always_comb begin
    err_nxt = (speed_r == '0);
    if (err_nxt)
      time_nxt = '0;
    else if (q > gcdt_pkg::QUO_W'(gcdt_pkg::TIME_MAX))
      time_nxt = gcdt_pkg::TIME_MAX;
    else
      time_nxt = q[gcdt_pkg::TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= div_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_r <= dq;
      out_time_r <= time_nxt;
      out_err_r  <= err_nxt;
    end
  end

  assign out_chan.valid            = out_vld_r;
  assign out_chan.distance         = out_dist_r;
  assign out_chan.travel_time      = out_time_r;
  assign out_chan.speed_zero_error = out_err_r;

`ifndef SYNTH
  a_err_tracks_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_err_r == (speed_r == '0)))
    else $error("error flag does not match speed register");

  a_err_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_err_r) |-> (out_time_r == '0))
    else $error("travel time nonzero with zero speed");

  a_h_range: assert property (@(posedge clk) disable iff (!rst_n)
    p3_vld_r |-> (h_r <= 31'(gcdt_pkg::Q30_ONE)))
    else $error("haversine term out of range");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for great_circle_distance_time_unit.
// Depends on gcdt_pkg, gcdt_in_if, gcdt_out_if and the RTL of the unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Config index past the end of the register list; the unit ignores it.
  localparam logic [gcdt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int  DRAIN_CYCLES = 160;     // beyond the full pipe depth
  localparam int  CYCLE_LIMIT  = 600000;
  localparam longint LAT_MAX = 94371840;
  localparam longint LON_MAX = 188743680;

  typedef struct packed {
    logic signed [gcdt_pkg::LAT_W-1:0] lat1;
    logic signed [gcdt_pkg::LON_W-1:0] lon1;
    logic signed [gcdt_pkg::LAT_W-1:0] lat2;
    logic signed [gcdt_pkg::LON_W-1:0] lon2;
  } route_t;

  typedef struct packed {
    logic [gcdt_pkg::DIST_W-1:0] span;
    logic [gcdt_pkg::TIME_W-1:0] ttime;
    logic                        zero_spd;
  } trip_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [gcdt_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [gcdt_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

  gcdt_in_if  in_chan ();
  gcdt_out_if out_chan ();

  great_circle_distance_time_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the unit's registers.
  logic [gcdt_pkg::RAD_W-1:0] radius_q = gcdt_pkg::RAD_RESET;
  logic [gcdt_pkg::SPD_W-1:0] speed_q  = gcdt_pkg::SPD_RESET;

  trip_t trips_due[$];
  int    err_cnt = 0;
  int    cyc = 0;
  bit    calm = 1'b0;      // when set neither side idles

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the pipe hangs.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor: fixed-point haversine, one turn = 2^32 phase, Q30 values.
  // ---------------------------------------------------------------------
  function automatic logic [31:0] deg_to_phase(input longint deg, input longint mul);
    longint p;
    p = (deg * mul) / 360;          // truncates toward zero
    return p[31:0];
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic rotate(input logic [31:0] ph, output longint sn, output longint cs);
    longint a, x, y, t;
    bit neg;
    a = longint'({32'b0, ph});
    x = gcdt_pkg::CORDIC_K;
    y = 0;
    neg = 1'b0;
    if (a >= gcdt_pkg::HALF_TURN) a -= 2 * gcdt_pkg::HALF_TURN;
    // fold into +-quarter turn, flip sign afterward
    if (a > gcdt_pkg::Q30_ONE) begin
      a -= gcdt_pkg::HALF_TURN;
      neg = 1'b1;
    end else if (a < -gcdt_pkg::Q30_ONE) begin
      a += gcdt_pkg::HALF_TURN;
      neg = 1'b1;
    end
    for (int i = 0; i < gcdt_pkg::TRIG_ITER && i < 40; i++) begin
      if (a >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        a -= longint'(gcdt_pkg::arc(i));
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        a += longint'(gcdt_pkg::arc(i));
      end
      x = t;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    cs = clip(x, -gcdt_pkg::Q30_ONE, gcdt_pkg::Q30_ONE);
    sn = clip(y, -gcdt_pkg::Q30_ONE, gcdt_pkg::Q30_ONE);
  endtask

  function automatic longint vector_angle(input longint x0, input longint y0);
    longint x, y, z, t;
    x = x0;
    y = y0;
    z = 0;
    for (int i = 0; i < gcdt_pkg::TRIG_ITER && i < 40; i++) begin
      // exact zero y leaves the angle untouched
      if (y > 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(gcdt_pkg::arc(i));
        x = t;
      end else if (y < 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(gcdt_pkg::arc(i));
        x = t;
      end
    end
    return clip(z, 0, gcdt_pkg::Q30_ONE);
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] v0);
    logic [63:0] v, res, b;
    v = v0;
    res = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic predict_trip(input route_t r, output trip_t e);
    longint la1, lo1, la2, lo2, s1, s2, c1, c2, unused, sq1, sq2, cc, hv, ang;
    logic [63:0] t, th, tl, d, tm;
    la1 = longint'(r.lat1);
    lo1 = longint'(r.lon1);
    la2 = longint'(r.lat2);
    lo2 = longint'(r.lon2);
    rotate(deg_to_phase(la2 - la1, 2048), s1, unused);
    rotate(deg_to_phase(lo2 - lo1, 2048), s2, unused);
    rotate(deg_to_phase(la1, 4096), unused, c1);
    rotate(deg_to_phase(la2, 4096), unused, c2);
    sq1 = (s1 * s1) >>> 30;
    sq2 = (s2 * s2) >>> 30;
    cc  = (c1 * c2) >>> 30;
    hv  = clip(sq1 + ((sq2 * cc) >>> 30), 0, gcdt_pkg::Q30_ONE);
    ang = vector_angle(longint'(int_root(64'(gcdt_pkg::Q30_ONE - hv) << 30)),
                       longint'(int_root(64'(hv) << 30)));
    t  = 64'(radius_q) * 64'(ang);
    th = t >> 30;
    tl = t & 64'h3FFF_FFFF;
    d  = (th * 64'(gcdt_pkg::PI_Q30) + ((tl * 64'(gcdt_pkg::PI_Q30)) >> 30)
          + (64'd1 << 29)) >> 30;
    if (d > 64'(gcdt_pkg::DIST_MAX)) d = 64'(gcdt_pkg::DIST_MAX);
    e.span = d[gcdt_pkg::DIST_W-1:0];
    if (speed_q == 0) begin
      e.ttime = '0;
      e.zero_spd = 1'b1;
    end else begin
      tm = (d << 16) / 64'(speed_q);
      e.ttime = tm > 64'(gcdt_pkg::TIME_MAX) ? gcdt_pkg::TIME_MAX
                                             : tm[gcdt_pkg::TIME_W-1:0];
      e.zero_spd = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure, compare each transfer in order.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else        out_chan.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cyc);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    trip_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (trips_due.size() == 0) begin
        report_mismatch("unexpected transfer", out_chan.distance, 0);
      end else begin
        want = trips_due.pop_front();
        if (out_chan.distance !== want.span)
          report_mismatch("distance", out_chan.distance, want.span);
        if (out_chan.travel_time !== want.ttime)
          report_mismatch("travel_time", out_chan.travel_time, want.ttime);
        if (out_chan.speed_zero_error !== want.zero_spd)
          report_mismatch("speed_zero_error", out_chan.speed_zero_error, want.zero_spd);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus side.
  // ---------------------------------------------------------------------

  // Push one route through the input channel; valid stays up across
  // back-to-back items so it only drops when an idle cycle is inserted.
  task automatic send_route(input route_t r);
    trip_t e;
    while (!calm && $urandom_range(99) < 26) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.start_latitude  <= r.lat1;
    in_chan.start_longitude <= r.lon1;
    in_chan.end_latitude    <= r.lat2;
    in_chan.end_longitude   <= r.lon2;
    do @(posedge clk); while (!in_chan.ready);
    predict_trip(r, e);
    trips_due = {trips_due, e};
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe empty.
  task automatic drain_pipe();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (trips_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gcdt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcdt_pkg::CFG_DAT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == gcdt_pkg::CFG_RADIUS) radius_q = val;
    else if (idx == gcdt_pkg::CFG_SPEED) speed_q = val;
  endtask

  function automatic route_t mk(input longint a, input longint b, input longint c,
                                input longint d);
    route_t r;
    r.lat1 = a[gcdt_pkg::LAT_W-1:0];
    r.lon1 = b[gcdt_pkg::LON_W-1:0];
    r.lat2 = c[gcdt_pkg::LAT_W-1:0];
    r.lon2 = d[gcdt_pkg::LON_W-1:0];
    return r;
  endfunction

  // Mostly in-range points; one in eight uses the whole field width so
  // every input bit toggles, including out-of-range wraparound.
  function automatic route_t rand_route();
    route_t r;
    if ($urandom_range(7) == 0) begin
      r = mk(longint'($urandom()), longint'($urandom()), longint'($urandom()),
             longint'($urandom()));
    end else begin
      r = mk(longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX,
             longint'($urandom_range(2 * LON_MAX)) - LON_MAX,
             longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX,
             longint'($urandom_range(2 * LON_MAX)) - LON_MAX);
      // nearby destination latitude now and then: small latitude differences
      if ($urandom_range(3) == 0)
        r.lat2 = r.lat1 + gcdt_pkg::LAT_W'(longint'($urandom_range(4095)) - 2048);
    end
    return r;
  endfunction

  // Corner geometry under reset defaults.
  task automatic test_directed();
    send_route(mk(0, 0, 0, 0));                          // identical at origin
    send_route(mk(12345678, -9876543, 12345678, -9876543)); // identical points
    send_route(mk(LAT_MAX, 0, -LAT_MAX, 0));             // pole to pole
    send_route(mk(0, -LON_MAX, 0, LON_MAX));             // full turn apart
    send_route(mk(0, 0, 0, LON_MAX));                    // antipodal on equator
    send_route(mk(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
    send_route(mk(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX)); // both at a pole
    send_route(mk(0, 0, 1, 0));                          // smallest step
    send_route(mk(0, 0, 0, 1));
    // field extremes, far outside +-90 / +-180
    send_route(mk(-(64'sd1 << 27), -(64'sd1 << 28), (64'sd1 << 27) - 1,
                  (64'sd1 << 28) - 1));
    send_route(mk((64'sd1 << 27) - 1, (64'sd1 << 28) - 1, -(64'sd1 << 27),
                  -(64'sd1 << 28)));
    send_route(mk(LAT_MAX + 1000, 0, 0, 0));             // latitude past a pole
    send_route(mk(42 << 20, -71 << 20, 51 << 20, 0));
    send_route(mk(-33 << 20, 151 << 20, 35 << 20, 139 << 20));
    drain_pipe();
  endtask

  // Register extremes: tiny and huge radius, zero, one and max speed.
  task automatic test_registers();
    write_reg(gcdt_pkg::CFG_SPEED, '0);                   // zero speed flag
    send_route(mk(0, 0, 0, LON_MAX));
    send_route(mk(0, 0, 0, 0));
    drain_pipe();
    write_reg(gcdt_pkg::CFG_RADIUS, {gcdt_pkg::CFG_DAT_W{1'b1}}); // largest radius
    write_reg(gcdt_pkg::CFG_SPEED, 24'd1);                // time saturates
    send_route(mk(0, 0, 0, LON_MAX));
    send_route(mk(0, 0, 1 << 20, 0));
    drain_pipe();
    write_reg(gcdt_pkg::CFG_RADIUS, 24'd1);
    write_reg(gcdt_pkg::CFG_SPEED, {gcdt_pkg::CFG_DAT_W{1'b1}});
    send_route(mk(0, 0, 0, LON_MAX));
    send_route(mk(LAT_MAX, 0, -LAT_MAX, 0));
    drain_pipe();
    write_reg(CFG_UNUSED, 24'hABCDEF);                    // must be ignored
    send_route(mk(10 << 20, 20 << 20, -30 << 20, 40 << 20));
    drain_pipe();
  endtask

  // Random routes across several register settings.
  task automatic test_random(input int n);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(gcdt_pkg::CFG_RADIUS, gcdt_pkg::RAD_RESET);
          write_reg(gcdt_pkg::CFG_SPEED, gcdt_pkg::SPD_RESET);
        end
        1: begin
          write_reg(gcdt_pkg::CFG_RADIUS, 24'($urandom()));
          write_reg(gcdt_pkg::CFG_SPEED, 24'($urandom_range(255, 1)));
        end
        2: begin
          write_reg(gcdt_pkg::CFG_RADIUS, {gcdt_pkg::CFG_DAT_W{1'b1}});
          write_reg(gcdt_pkg::CFG_SPEED, '0);
        end
        3: begin
          write_reg(gcdt_pkg::CFG_RADIUS, 24'($urandom_range(4095, 1)));
          write_reg(gcdt_pkg::CFG_SPEED, 24'($urandom()));
        end
        default: begin
          write_reg(gcdt_pkg::CFG_RADIUS, 24'($urandom()) | 24'd1);
          write_reg(gcdt_pkg::CFG_SPEED, 24'($urandom()));
        end
      endcase
      // long stretch without idling in the middle phase
      calm = (ph == 2);
      for (int k = 0; k < n / 5; k++) send_route(rand_route());
      calm = 1'b0;
      drain_pipe();
    end
  endtask

  // Ten routes, a hold-off until every outstanding result has come back, then ten more.
  task automatic test_pause_mid_stream();
    for (int k = 0; k < 10; k++) send_route(rand_route());
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (trips_due.size() != 0) @(posedge clk);
    for (int k = 0; k < 10; k++) send_route(rand_route());
    drain_pipe();
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.start_latitude = '0;
    in_chan.start_longitude = '0;
    in_chan.end_latitude = '0;
    in_chan.end_longitude = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_registers();
    test_random(810);
    test_pause_mid_stream();
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gcdt_pkg.sv
rtl/gcdt_in_if.sv
rtl/gcdt_out_if.sv
rtl/gcdt_phase.sv
rtl/gcdt_rot.sv
rtl/gcdt_isqrt.sv
rtl/gcdt_vec.sv
rtl/gcdt_div.sv
rtl/great_circle_distance_time_unit.sv
tb/sv/tb_top.sv
